/* rtl/c16fca_pkg.sv */
// ----------------------------------------------------------------------------
// CRC-16 frame check package
// Shared constants, codes and the one-bit CRC step used by the frame checker.
// ----------------------------------------------------------------------------
package c16fca_pkg;

   // Default size of the frame store in bytes.
   localparam int FRAME_MAX_DEFAULT = 32;

   // Reflected CRC-16 polynomial and preset.
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [15:0] CRC_PRESET = 16'hFFFF;

   // Result kinds.
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ACK    = 1'b1;

   // Status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LOW_BAD  = 3'd1;
   localparam logic [2:0] ST_HIGH_BAD = 3'd2;
   localparam logic [2:0] ST_SHORT    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // Command word for the shared CRC unit.
   typedef struct packed {
      logic       init;   // Load the preset.
      logic       load;   // XOR a byte in and take the first bit step.
      logic       step;   // Take one bit step.
      logic [7:0] data;
   } crc_ctrl_type;

   // One bit step of the reflected CRC.
   function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
      logic [15:0] shifted;
      shifted = {1'b0, crc[15:1]};
      if (crc[0]) begin
         return shifted ^ CRC_POLY;
      end
      return shifted;
   endfunction

endpackage

/* rtl/c16fca_req_if.sv */
// ----------------------------------------------------------------------------
// Frame byte channel
// Carries one received frame byte and its end marker per word.
// ----------------------------------------------------------------------------
interface c16fca_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, data_byte, frame_end, input ready);
   modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

/* rtl/c16fca_rsp_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Carries status words and acknowledge frame bytes.
// ----------------------------------------------------------------------------
interface c16fca_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [2:0] status;
   logic [7:0] ack_byte;
   logic       last;

   modport source (output valid, result_kind, status, ack_byte, last, input ready);
   modport sink   (input valid, result_kind, status, ack_byte, last, output ready);
endinterface

/* rtl/c16fca_csr_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the write data of the acknowledge enable register.
// ----------------------------------------------------------------------------
interface c16fca_csr_if;
   logic valid;
   logic ready;
   logic ack_enable;

   modport source (output valid, ack_enable, input ready);
   modport sink   (input valid, ack_enable, output ready);
endinterface

/* rtl/crc16_frame_check_and_ack.sv */
// ----------------------------------------------------------------------------
// CRC-16 frame checker with acknowledge generator
// Checks the trailing reflected CRC-16 of each frame and optionally answers
// a good frame with an acknowledge frame.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the req channel, one word per byte, with frame_end set
// on the final byte. The running CRC is folded bit-serially, two bytes behind
// the newest one, so a stored byte passes bit by bit through the shared CRC unit;
// the first two bytes of a frame and dropped bytes skip the fold. req ready is
// low while the CRC unit is busy or results are being sent.
// After the end word the block sends one status word on the rsp channel. When
// ack_enable is set and the CRC is good, the acknowledge frame follows, one
// byte per word, with last on its final byte. Each acknowledge data byte is
// read from the store and folded through the same CRC unit before the next one
// is read; the two CRC bytes then follow.
// The status word is loaded in the status state, which follows the fold of the
// end word, or the end word itself when it is the first or second byte or is dropped.
// A finished word waits in the output register when the receiver stalls, and
// the sequencer holds until that register is free.
// The csr channel is always ready and writes ack_enable; write it only while
// the block is idle. Reset clears the byte count, overflow flag, ack_enable
// and the output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module crc16_frame_check_and_ack
   import c16fca_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   c16fca_req_if.sink   req_ch,
   c16fca_rsp_if.source rsp_ch,
   c16fca_csr_if.sink   csr_ch
);

   localparam int AW = $clog2(FRAME_MAX);
   localparam int CW = $clog2(FRAME_MAX + 1);
   localparam logic [CW-1:0] FRAME_MAX_C = CW'(FRAME_MAX);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FOLD   = 3'd1;
   localparam logic [2:0] S_STATUS = 3'd2;
   localparam logic [2:0] S_RD     = 3'd3;
   localparam logic [2:0] S_LD     = 3'd4;
   localparam logic [2:0] S_ACRC   = 3'd5;
   localparam logic [2:0] S_CRCLO  = 3'd6;
   localparam logic [2:0] S_CRCHI  = 3'd7;

   logic [2:0]    state_ff,  state_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          ovf_ff,    ovf_in;
   logic          end_ff,    end_in;
   logic [7:0]    lag0_ff,   lag0_in;
   logic [7:0]    lag1_ff,   lag1_in;
   logic [2:0]    bit_ff,    bit_in;
   logic [CW-1:0] idx_ff,    idx_in;
   logic [CW-1:0] m_ff,      m_in;
   logic          ack_en_ff;

   logic          rsp_valid_ff;
   logic          kind_ff,   kind_in;
   logic [2:0]    status_ff, status_in;
   logic [7:0]    byte_ff,   byte_in;
   logic          last_ff,   last_in;
   logic          out_load;

   crc_ctrl_type  crc_ctrl;
   logic [15:0]   crc_value;
   logic [15:0]   crc_final;
   logic          store_wr;
   logic [7:0]    rd_data;

   logic          req_fire;
   logic          store_ok;
   logic          fold_need;
   logic          out_free;
   logic [2:0]    frame_status;
   logic          do_ack;
   logic [CW-1:0] ack_len;
   logic [7:0]    ack_data;

   // Shared CRC unit and frame store.
   c16fca_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (crc_ctrl),
      .crc_value (crc_value)
   );

   c16fca_store #(
      .DEPTH (FRAME_MAX),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_ch.data_byte),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Handshake decodes.
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);
   assign store_ok     = (count_ff < FRAME_MAX_C);
   assign fold_need    = store_ok && (count_ff > CW'(1));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign crc_final    = ~crc_value;

   // Frame verdict, valid in the status state.
   always_comb begin
      if (ovf_ff) begin
         frame_status = ST_OVERFLOW;
      end else if (count_ff < CW'(3)) begin
         frame_status = ST_SHORT;
      end else if (lag1_ff != crc_final[7:0]) begin
         frame_status = ST_LOW_BAD;
      end else if (lag0_ff != crc_final[15:8]) begin
         frame_status = ST_HIGH_BAD;
      end else begin
         frame_status = ST_OK;
      end
   end

   assign do_ack  = (frame_status == ST_OK) && ack_en_ff;
   // A six-byte frame is answered with a seven-byte acknowledge.
   assign ack_len = (count_ff == CW'(6)) ? CW'(5) : count_ff - CW'(2);
   // The byte just before the acknowledge CRC is cleared.
   assign ack_data = (idx_ff == m_ff - CW'(1)) ? 8'h00 : rd_data;

   // Sequencer next-state logic.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      end_in    = end_ff;
      lag0_in   = lag0_ff;
      lag1_in   = lag1_ff;
      bit_in    = bit_ff;
      idx_in    = idx_ff;
      m_in      = m_ff;
      crc_ctrl  = '0;
      store_wr  = 1'b0;
      out_load  = 1'b0;
      kind_in   = KIND_STATUS;
      status_in = ST_OK;
      byte_in   = 8'h00;
      last_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               end_in = req_ch.frame_end;
               if (store_ok) begin
                  store_wr = 1'b1;
                  count_in = count_ff + CW'(1);
                  lag0_in  = req_ch.data_byte;
                  lag1_in  = lag0_ff;
               end else begin
                  ovf_in = 1'b1;
               end
               if (fold_need) begin
                  crc_ctrl.load = 1'b1;
                  crc_ctrl.data = lag1_ff;
                  bit_in        = 3'd1;
                  state_in      = S_FOLD;
               end else if (req_ch.frame_end) begin
                  state_in = S_STATUS;
               end
            end
         end
         S_FOLD: begin
            crc_ctrl.step = 1'b1;
            bit_in        = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               state_in = end_ff ? S_STATUS : S_IDLE;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               out_load      = 1'b1;
               kind_in       = KIND_STATUS;
               status_in     = frame_status;
               last_in       = !do_ack;
               count_in      = '0;
               ovf_in        = 1'b0;
               crc_ctrl.init = 1'b1;
               idx_in        = '0;
               m_in          = ack_len;
               state_in      = do_ack ? S_RD : S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_LD;
         end
         S_LD: begin
            if (out_free) begin
               out_load      = 1'b1;
               kind_in       = KIND_ACK;
               byte_in       = ack_data;
               crc_ctrl.load = 1'b1;
               crc_ctrl.data = ack_data;
               bit_in        = 3'd1;
               state_in      = S_ACRC;
            end
         end
         S_ACRC: begin
            crc_ctrl.step = 1'b1;
            bit_in        = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               idx_in   = idx_ff + CW'(1);
               state_in = (idx_ff + CW'(1) == m_ff) ? S_CRCLO : S_RD;
            end
         end
         S_CRCLO: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = KIND_ACK;
               byte_in  = crc_final[7:0];
               state_in = S_CRCHI;
            end
         end
         S_CRCHI: begin
            if (out_free) begin
               out_load      = 1'b1;
               kind_in       = KIND_ACK;
               byte_in       = crc_final[15:8];
               last_in       = 1'b1;
               crc_ctrl.init = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         end_ff    <= 1'b0;
         bit_ff    <= '0;
         ack_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         end_ff   <= end_in;
         bit_ff   <= bit_in;
         if (csr_ch.valid) begin
            ack_en_ff <= csr_ch.ack_enable;
         end
      end
   end

   // Byte window and acknowledge indexes.
   always_ff @(posedge clock) begin
      lag0_ff <= lag0_in;
      lag1_ff <= lag1_in;
      idx_ff  <= idx_in;
      m_ff    <= m_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         byte_ff   <= byte_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.ack_byte    = byte_ff;
   assign rsp_ch.last        = last_ff;

endmodule

/* rtl/c16fca_crc_unit.sv */
// ----------------------------------------------------------------------------
// Bit-serial CRC-16 unit
// Holds the running CRC and advances it by one bit per command.
// ----------------------------------------------------------------------------
module c16fca_crc_unit
   import c16fca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   output logic [15:0]  crc_value
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   // Preset, byte load with first step, or a plain bit step.
   always_comb begin
      crc_in = crc_ff;
      if (ctrl.init) begin
         crc_in = CRC_PRESET;
      end else if (ctrl.load) begin
         crc_in = crc_bit_step(crc_ff ^ {8'h00, ctrl.data});
      end else if (ctrl.step) begin
         crc_in = crc_bit_step(crc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_PRESET;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule

/* rtl/c16fca_store.sv */
// ----------------------------------------------------------------------------
// Frame store
// Single-port write, single-port read byte memory with registered read data.
// ----------------------------------------------------------------------------
module c16fca_store
   import c16fca_pkg::*;
#(
   parameter int DEPTH = FRAME_MAX_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
